// File: src/mard_pkg.sv
`default_nettype none

package mard_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CH_IN_W    = 4;
    localparam int AVG_W      = 12;
    localparam int MASK_W     = 14;
    localparam int THR_W      = 16;
    localparam int LIMIT_W    = 12;
    localparam int MULT_W     = 4;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = CFG_IDX_W'(1);

    localparam logic [LIMIT_W-1:0] ABS_LIMIT_RST = LIMIT_W'(1200);
    localparam logic [MULT_W-1:0]  RATIO_RST     = MULT_W'(2);

    localparam int CHANNELS_DEF = 16;
    localparam int WINDOW_DEF   = 8;
    localparam int BINS_DEF     = 14;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [MASK_W-1:0]   mask_t;

endpackage

`default_nettype wire

// File: src/multichannel_average_relative_detector_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    channel, sample_mv
// out       output     out_valid / out_ready  channel_average, detect_mask, previous_mask,
//                                             mask_changed, relative_threshold
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One transaction at a time: after a sample is accepted, in_ready stays low through two
// passes over the channel memory and the reciprocal dividers for the channel average and
// the mean. The result shows in the cycle in which in_ready rises again.
// After reset a clearing pass over all CHANNELS*WINDOW window entries zeroes both
// memories; in_ready stays low meanwhile. Loading a result waits only while the previous
// one is not taken.
`default_nettype none

module multichannel_average_relative_detector_top #(
    parameter int CHANNELS = mard_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mard_pkg::WINDOW_DEF,
    parameter int BINS     = mard_pkg::BINS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mard_pkg::CH_IN_W-1:0]      channel,
    input  wire logic [mard_pkg::SAMPLE_W-1:0]     sample_mv,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mard_pkg::AVG_W-1:0]             channel_average,
    output logic [mard_pkg::MASK_W-1:0]            detect_mask,
    output logic [mard_pkg::MASK_W-1:0]            previous_mask,
    output logic                                   mask_changed,
    output logic [mard_pkg::THR_W-1:0]             relative_threshold,
    input  wire logic                              cfg_we,
    input  wire logic [mard_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mard_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import mard_pkg::*;

    localparam int CHI_W     = $clog2(CHANNELS);
    localparam int POS_W     = $clog2(WINDOW);
    localparam int WIN_DEPTH = CHANNELS * WINDOW;
    localparam int WA_W      = $clog2(WIN_DEPTH);
    localparam int CLR_W     = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int TOT_W     = AVG_W + $clog2(BINS);
    localparam int SCAN_W    = $clog2(BINS + 1);
    localparam int CMEM_W    = SUM_W + AVG_W;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_READ   = 4'd2;
    localparam logic [3:0] ST_UPD    = 4'd3;
    localparam logic [3:0] ST_DIVA   = 4'd4;
    localparam logic [3:0] ST_SCAN1  = 4'd5;
    localparam logic [3:0] ST_MSTART = 4'd6;
    localparam logic [3:0] ST_DIVM   = 4'd7;
    localparam logic [3:0] ST_SCAN2  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [POS_W-1:0]   pos_reg [CHANNELS];
    logic [POS_W-1:0]   pos_next [CHANNELS];
    logic [LIMIT_W-1:0] limit_reg;
    logic [MULT_W-1:0]  ratio_reg;

    logic [CH_IN_W-1:0] ch_reg, ch_next;
    sample_t            smp_reg, smp_next;
    logic [SUM_W-1:0]   newsum_reg, newsum_next;
    logic [AVG_W-1:0]   chavg_reg, chavg_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic               poor_reg, poor_next;
    logic [SCAN_W-1:0]  pidx_reg, pidx_next;
    logic [TOT_W-1:0]   tot_reg, tot_next;
    logic [AVG_W-1:0]   max_reg, max_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    mask_t              mask_reg, mask_next;
    mask_t              last_mask_reg, last_mask_next;

    logic               out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]   oavg_reg, oavg_next;
    mask_t              omask_reg, omask_next;
    mask_t              oprev_reg, oprev_next;
    logic               ochg_reg, ochg_next;
    logic [THR_W-1:0]   othr_reg, othr_next;

    sample_t            win_mem [WIN_DEPTH];
    logic               win_we, win_re;
    logic [WA_W-1:0]    win_wa, win_ra;
    sample_t            win_wd;
    sample_t            win_rdata_reg;

    logic [CMEM_W-1:0]  chan_mem [CHANNELS];
    logic               chan_we, chan_re;
    logic [CHI_W-1:0]   chan_wa, chan_ra;
    logic [CMEM_W-1:0]  chan_wd;
    logic [CMEM_W-1:0]  chan_rdata_reg;

    logic               avg_start;
    logic [SUM_W-1:0]   avg_quotient;
    logic               avg_done;
    logic               mean_start;
    logic [TOT_W-1:0]   mean_dividend;
    logic [TOT_W-1:0]   mean_quotient;
    logic               mean_done;

    logic [CHI_W-1:0]   ch_idx;
    logic               ch_ok;
    logic [WA_W-1:0]    slot;
    logic [SUM_W-1:0]   sum_calc;
    logic [AVG_W-1:0]   scan_avg;
    logic               scan_oor;

    mard_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (WINDOW)
    ) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (sum_calc),
        .quotient (avg_quotient),
        .done     (avg_done)
    );

    mard_div #(
        .DIVIDEND_W (TOT_W),
        .DIVISOR    (BINS - 1)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mean_start),
        .dividend (mean_dividend),
        .quotient (mean_quotient),
        .done     (mean_done)
    );

    assign ch_idx   = CHI_W'(ch_reg);
    assign ch_ok    = 32'(ch_reg) < 32'(CHANNELS);
    assign slot     = WA_W'(WA_W'(ch_idx) * WA_W'(WINDOW)) + WA_W'(pos_reg[ch_idx]);
    assign sum_calc = chan_rdata_reg[CMEM_W-1:AVG_W] - SUM_W'(win_rdata_reg)
                      + SUM_W'(smp_reg);
    assign scan_avg = poor_reg ? '0 : chan_rdata_reg[AVG_W-1:0];
    assign scan_oor = 32'(scan_reg) >= 32'(CHANNELS);
    assign mean_dividend = tot_reg - TOT_W'(max_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        smp_next       = smp_reg;
        newsum_next    = newsum_reg;
        chavg_next     = chavg_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        poor_next      = poor_reg;
        pidx_next      = pidx_reg;
        tot_next       = tot_reg;
        max_next       = max_reg;
        thr_next       = thr_reg;
        mask_next      = mask_reg;
        last_mask_next = last_mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        oavg_next      = oavg_reg;
        omask_next     = omask_reg;
        oprev_next     = oprev_reg;
        ochg_next      = ochg_reg;
        othr_next      = othr_reg;
        win_we         = 1'b0;
        win_re         = 1'b0;
        win_wa         = slot;
        win_ra         = slot;
        win_wd         = smp_reg;
        chan_we        = 1'b0;
        chan_re        = 1'b0;
        chan_wa        = ch_idx;
        chan_ra        = ch_idx;
        chan_wd        = {newsum_reg, avg_quotient[AVG_W-1:0]};
        avg_start      = 1'b0;
        mean_start     = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                win_we  = 1'b1;
                win_wa  = WA_W'(clr_reg);
                win_wd  = '0;
                chan_we = 32'(clr_reg) < 32'(CHANNELS);
                chan_wa = CHI_W'(clr_reg);
                chan_wd = '0;
                clr_next = clr_reg + CLR_W'(1);
                if (32'(clr_reg) == WIN_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = channel;
                    smp_next   = sample_mv;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                scan_next = '0;
                tot_next  = '0;
                max_next  = '0;
                if (ch_ok)
                begin
                    win_re     = 1'b1;
                    chan_re    = 1'b1;
                    state_next = ST_UPD;
                end
                else
                begin
                    chavg_next = '0;
                    state_next = ST_SCAN1;
                end
            end
            ST_UPD:
            begin
                newsum_next = sum_calc;
                win_we      = 1'b1;
                avg_start   = 1'b1;
                pos_next[ch_idx] = (32'(pos_reg[ch_idx]) == WINDOW - 1) ?
                                   '0 : pos_reg[ch_idx] + POS_W'(1);
                state_next  = ST_DIVA;
            end
            ST_DIVA:
            begin
                if (avg_done)
                begin
                    chan_we    = 1'b1;
                    chavg_next = avg_quotient[AVG_W-1:0];
                    state_next = ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                if (pend_reg)
                begin
                    tot_next = tot_reg + TOT_W'(scan_avg);
                    if (scan_avg > max_reg)
                    begin
                        max_next = scan_avg;
                    end
                end
                if (32'(scan_reg) < BINS)
                begin
                    chan_re   = !scan_oor;
                    chan_ra   = CHI_W'(scan_reg);
                    pend_next = 1'b1;
                    poor_next = scan_oor;
                    pidx_next = scan_reg;
                    scan_next = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART:
            begin
                mean_start = 1'b1;
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                if (mean_done)
                begin
                    thr_next   = THR_W'(mean_quotient[AVG_W-1:0]) * THR_W'(ratio_reg);
                    scan_next  = '0;
                    mask_next  = '0;
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2:
            begin
                if (pend_reg && 32'(pidx_reg) < MASK_W)
                begin
                    if (THR_W'(scan_avg) > thr_reg || scan_avg > limit_reg)
                    begin
                        mask_next = mask_reg | (MASK_W'(1) << pidx_reg);
                    end
                end
                if (32'(scan_reg) < BINS)
                begin
                    chan_re   = !scan_oor;
                    chan_ra   = CHI_W'(scan_reg);
                    pend_next = 1'b1;
                    poor_next = scan_oor;
                    pidx_next = scan_reg;
                    scan_next = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oavg_next      = chavg_reg;
                    omask_next     = mask_reg;
                    oprev_next     = last_mask_reg;
                    ochg_next      = mask_reg != last_mask_reg;
                    othr_next      = thr_reg;
                    last_mask_next = mask_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            last_mask_reg <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= ABS_LIMIT_RST;
            ratio_reg     <= RATIO_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            last_mask_reg <= last_mask_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ABS_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_RATIO:     ratio_reg <= cfg_data[MULT_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        smp_reg    <= smp_next;
        newsum_reg <= newsum_next;
        chavg_reg  <= chavg_next;
        scan_reg   <= scan_next;
        poor_reg   <= poor_next;
        pidx_reg   <= pidx_next;
        tot_reg    <= tot_next;
        max_reg    <= max_next;
        thr_reg    <= thr_next;
        mask_reg   <= mask_next;
        oavg_reg   <= oavg_next;
        omask_reg  <= omask_next;
        oprev_reg  <= oprev_next;
        ochg_reg   <= ochg_next;
        othr_reg   <= othr_next;
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_wa] <= win_wd;
        end
        if (win_re)
        begin
            win_rdata_reg <= win_mem[win_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chan_we)
        begin
            chan_mem[chan_wa] <= chan_wd;
        end
        if (chan_re)
        begin
            chan_rdata_reg <= chan_mem[chan_ra];
        end
    end

    assign in_ready           = state_reg == ST_IDLE;
    assign out_valid          = out_valid_reg;
    assign channel_average    = oavg_reg;
    assign detect_mask        = omask_reg;
    assign previous_mask      = oprev_reg;
    assign mask_changed       = ochg_reg;
    assign relative_threshold = othr_reg;

endmodule

`default_nettype wire

// File: src/mard_div.sv
`default_nettype none

module mard_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR    = 13
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic                       done
);

    localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int RECIP_W = DIVIDEND_W + 1;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [PROD_W-1:0]     product;

    // The dividend is registered first, then multiplied by the rounded-up reciprocal.
    assign product = {{RECIP_W{1'b0}}, dvd_reg} * {{DIVIDEND_W{1'b0}}, RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        if (busy_reg)
        begin
            quo_reg <= DIVIDEND_W'(product >> SHIFT);
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: src/mard_checker.sv
`default_nettype none

module mard_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [mard_pkg::MASK_W-1:0]    detect_mask,
    input wire logic [mard_pkg::MASK_W-1:0]    previous_mask,
    input wire logic                           mask_changed,
    input wire logic [mard_pkg::THR_W-1:0]     relative_threshold
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted right after the first");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mask_changed == (detect_mask != previous_mask))
        else $error("mask_changed disagrees with the masks");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after acceptance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(detect_mask)
            && $stable(relative_threshold))
        else $error("stalled result changed");

endmodule

bind multichannel_average_relative_detector_top mard_checker u_mard_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .detect_mask        (detect_mask),
    .previous_mask      (previous_mask),
    .mask_changed       (mask_changed),
    .relative_threshold (relative_threshold)
);

`default_nettype wire
